// File: rtl/adpc_pkg.sv
package adpc_pkg;

    // reply fifo
    localparam int REPLY_DEPTH = 16;
    localparam int REPLY_AW    = $clog2(REPLY_DEPTH);
    localparam int REPLY_CW    = REPLY_AW + 1;

    // item kinds
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // port offsets
    localparam logic [3:0] PORT_MIX_INDEX = 4'h4;
    localparam logic [3:0] PORT_MIX_DATA  = 4'h5;
    localparam logic [3:0] PORT_RESET     = 4'h6;
    localparam logic [3:0] PORT_READ_DATA = 4'hA;
    localparam logic [3:0] PORT_COMMAND   = 4'hC;
    localparam logic [3:0] PORT_STATUS    = 4'hE;

    // commands
    localparam logic [7:0] CMD_DIRECT_DAC = 8'h10;
    localparam logic [7:0] CMD_DMA_8      = 8'h14;
    localparam logic [7:0] CMD_DMA_2BIT   = 8'h24;
    localparam logic [7:0] CMD_DMA_HS     = 8'h91;
    localparam logic [7:0] CMD_AUTO_8     = 8'h1C;
    localparam logic [7:0] CMD_AUTO_2BIT  = 8'h2C;
    localparam logic [7:0] CMD_TIME_CONST = 8'h40;
    localparam logic [7:0] CMD_BLOCK_SIZE = 8'h48;
    localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
    localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;
    localparam logic [7:0] CMD_SPK_STATUS = 8'hD8;
    localparam logic [7:0] CMD_DMA_EXIT   = 8'hDA;
    localparam logic [7:0] CMD_INVERT     = 8'hE0;
    localparam logic [7:0] CMD_IDENTIFY   = 8'hE1;
    localparam logic [7:0] CMD_TEST_WRITE = 8'hE4;
    localparam logic [7:0] CMD_TEST_READ  = 8'hE8;
    localparam logic [7:0] CMD_FORCE_IRQ  = 8'hF2;
    localparam logic [7:0] CMD_IRQ_TEST   = 8'hF8;

    // argument phases
    localparam logic [1:0] ARG_NONE   = 2'd0;
    localparam logic [1:0] ARG_SINGLE = 2'd1;
    localparam logic [1:0] ARG_LOW    = 2'd2;
    localparam logic [1:0] ARG_HIGH   = 2'd3;

    // configuration register indexes
    localparam logic CFG_VERSION_MAJOR = 1'b0;
    localparam logic CFG_VERSION_MINOR = 1'b1;

    localparam logic [7:0]  RESET_ACK     = 8'hAA;
    localparam logic [7:0]  MIXER_FILL    = 8'hEE;
    localparam logic [7:0]  DAC_MIDSCALE  = 8'd128;
    localparam logic [15:0] BLOCK_MAX     = 16'd65535;
    localparam logic [7:0]  STATUS_READY  = 8'h80;
    localparam logic [7:0]  SPK_REPLY_ON  = 8'hFF;

    typedef struct packed {
        logic       rd_en;
        logic [7:0] raddr;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       clear;
    } mixer_req_t;

endpackage

// File: rtl/adpc_mixer.sv
module adpc_mixer (
    input  logic                aclk,
    input  logic                aresetn,
    input  adpc_pkg::mixer_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0]   mem [256];
    logic [7:0]   mem_q_reg;
    logic [7:0]   raddr_reg;
    logic         byp_reg;
    logic [7:0]   byp_data_reg;
    logic [255:0] valid_reg;
    logic [7:0]   fill_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd_en) begin
            mem_q_reg <= mem[req.raddr];
        end
    end

    // a write at the read address in the same cycle wins over the old word
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            raddr_reg    <= req.raddr;
            byp_reg      <= req.we && (req.waddr == req.raddr);
            byp_data_reg <= req.wdata;
        end
    end

    // entries never written since reset or the last clear read as fill_reg: zero after reset, MIXER_FILL after a clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= 8'd0;
        end else if (req.clear) begin
            valid_reg <= '0;
            fill_reg  <= adpc_pkg::MIXER_FILL;
        end else if (req.we) begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    assign rdata = valid_reg[raddr_reg] ? (byp_reg ? byp_data_reg : mem_q_reg) : fill_reg;

endmodule

// File: rtl/audio_dsp_port_controller.sv
// Sound card DSP port controller. Each input transaction is a port write,
// a port read or a sample tick (s_tuser), and each one yields exactly one
// result transaction holding the read byte, an interrupt flag and the current
// output level. Items go through an input register and a result register with
// short logic between them, so one item is taken every cycle unless
// m_tready stalls the output; the mixer bank is a 256-byte memory read at
// the pointer the previous item leaves, as the item is accepted. The user
// must set the version bytes of the identify command through the write port
// only while the block is idle; the block itself does not enforce this.
module audio_dsp_port_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // port[3:0], write_data[11:4], dma_sample[19:12], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_data[7:0], irq_request[8], audio_level[16:9], pad
);

    localparam int AW = adpc_pkg::REPLY_AW;
    localparam int CW = adpc_pkg::REPLY_CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(adpc_pkg::REPLY_DEPTH);

    // handshake and pipeline registers
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [3:0]  in_port_reg;
    logic [7:0]  in_wd_reg;
    logic [7:0]  in_ds_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        advance;
    logic        s_accept;

    // block state
    logic [7:0]    ver_major_reg, ver_minor_reg;
    logic          armed_reg, armed_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    reply_store_reg [adpc_pkg::REPLY_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          spk_reg, spk_next;
    logic [7:0]    dac_reg, dac_next;
    logic          dma_reg, dma_next;
    logic          auto_reg, auto_next;
    logic [15:0]   len_reg, len_next;
    logic [16:0]   pos_reg, pos_next;
    logic [7:0]    test_reg, test_next;
    logic [7:0]    ptr_reg, ptr_next;

    // per-item results and fifo requests
    logic [7:0]    rd;
    logic          irq;
    logic          fifo_clr;
    logic [1:0]    push_n;
    logic [7:0]    push0, push1;
    logic          pop;
    logic          we0, we1;
    logic [AW-1:0] tail0, tail1;
    logic [AW-1:0] base_head;
    logic [CW-1:0] base_count, count1;
    logic [16:0]   pos_inc;
    logic          mix_we, mix_clr;
    logic [7:0]    mix_rdata;
    adpc_pkg::mixer_req_t mix_req;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = {2'b00, h} + {1'b0, c};
        if (sum >= {1'b0, DEPTH_C}) begin
            sum = sum - {1'b0, DEPTH_C};
        end
        return sum[AW-1:0];
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= s_tuser;
            in_port_reg   <= s_tdata[3:0];
            in_wd_reg     <= s_tdata[11:4];
            in_ds_reg     <= s_tdata[19:12];
        end
        if (advance) begin
            out_data_reg <= {7'd0, (spk_next ? dac_next : 8'd0), irq, rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_major_reg <= 8'd2;
            ver_minor_reg <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                adpc_pkg::CFG_VERSION_MAJOR: ver_major_reg <= cfg_wdata;
                adpc_pkg::CFG_VERSION_MINOR: ver_minor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        armed_next = armed_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        spk_next   = spk_reg;
        dac_next   = dac_reg;
        dma_next   = dma_reg;
        auto_next  = auto_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        test_next  = test_reg;
        ptr_next   = ptr_reg;
        rd         = 8'd0;
        irq        = 1'b0;
        fifo_clr   = 1'b0;
        push_n     = 2'd0;
        push0      = 8'd0;
        push1      = 8'd0;
        pop        = 1'b0;
        mix_we     = 1'b0;
        mix_clr    = 1'b0;
        pos_inc    = pos_reg + 17'd1;

        if (advance) begin
            unique case (in_action_reg)
                adpc_pkg::ACT_WRITE: begin
                    unique case (in_port_reg)
                        adpc_pkg::PORT_MIX_INDEX: ptr_next = in_wd_reg;
                        adpc_pkg::PORT_MIX_DATA:  mix_we = 1'b1;
                        adpc_pkg::PORT_RESET: begin
                            if (in_wd_reg == 8'd0 && armed_reg) begin
                                spk_next   = 1'b0;
                                dac_next   = adpc_pkg::DAC_MIDSCALE;
                                phase_next = adpc_pkg::ARG_NONE;
                                dma_next   = 1'b0;
                                len_next   = adpc_pkg::BLOCK_MAX;
                                pos_next   = 17'd0;
                                fifo_clr   = 1'b1;
                                push_n     = 2'd1;
                                push0      = adpc_pkg::RESET_ACK;
                                mix_clr    = 1'b1;
                            end
                            armed_next = (in_wd_reg == 8'd1);
                        end
                        adpc_pkg::PORT_COMMAND: begin
                            if (phase_reg != adpc_pkg::ARG_NONE) begin
                                // argument byte for the pending command
                                phase_next = adpc_pkg::ARG_NONE;
                                unique case (cmd_reg)
                                    adpc_pkg::CMD_DIRECT_DAC: dac_next = in_wd_reg;
                                    adpc_pkg::CMD_DMA_8, adpc_pkg::CMD_DMA_2BIT,
                                    adpc_pkg::CMD_DMA_HS, adpc_pkg::CMD_BLOCK_SIZE: begin
                                        if (phase_reg == adpc_pkg::ARG_LOW) begin
                                            len_next   = {len_reg[15:8], in_wd_reg};
                                            phase_next = adpc_pkg::ARG_HIGH;
                                        end else begin
                                            len_next = {in_wd_reg, len_reg[7:0]};
                                            pos_next = 17'd0;
                                            if (cmd_reg != adpc_pkg::CMD_BLOCK_SIZE) begin
                                                dma_next  = 1'b1;
                                                auto_next = 1'b0;
                                                spk_next  = 1'b1;
                                            end
                                        end
                                    end
                                    adpc_pkg::CMD_INVERT: begin
                                        push_n = 2'd1;
                                        push0  = ~in_wd_reg;
                                    end
                                    adpc_pkg::CMD_TEST_WRITE: begin
                                        push_n    = 2'd1;
                                        push0     = in_wd_reg;
                                        test_next = in_wd_reg;
                                    end
                                    default: ;
                                endcase
                            end else begin
                                cmd_next = in_wd_reg;
                                unique case (in_wd_reg)
                                    adpc_pkg::CMD_DIRECT_DAC, adpc_pkg::CMD_TIME_CONST,
                                    adpc_pkg::CMD_INVERT, adpc_pkg::CMD_TEST_WRITE:
                                        phase_next = adpc_pkg::ARG_SINGLE;
                                    adpc_pkg::CMD_DMA_8, adpc_pkg::CMD_DMA_2BIT,
                                    adpc_pkg::CMD_BLOCK_SIZE, adpc_pkg::CMD_DMA_HS:
                                        phase_next = adpc_pkg::ARG_LOW;
                                    adpc_pkg::CMD_AUTO_8, adpc_pkg::CMD_AUTO_2BIT: begin
                                        dma_next  = 1'b1;
                                        pos_next  = 17'd0;
                                        auto_next = 1'b1;
                                        spk_next  = 1'b1;
                                    end
                                    adpc_pkg::CMD_SPK_ON:  spk_next = 1'b1;
                                    adpc_pkg::CMD_SPK_OFF: spk_next = 1'b0;
                                    adpc_pkg::CMD_SPK_STATUS: begin
                                        push_n = 2'd1;
                                        push0  = spk_reg ? adpc_pkg::SPK_REPLY_ON : 8'd0;
                                    end
                                    adpc_pkg::CMD_DMA_EXIT: dma_next = 1'b0;
                                    adpc_pkg::CMD_IDENTIFY: begin
                                        fifo_clr = 1'b1;
                                        push_n   = 2'd2;
                                        push0    = ver_major_reg;
                                        push1    = ver_minor_reg;
                                    end
                                    adpc_pkg::CMD_TEST_READ: begin
                                        fifo_clr = 1'b1;
                                        push_n   = 2'd1;
                                        push0    = test_reg;
                                    end
                                    adpc_pkg::CMD_FORCE_IRQ: irq = 1'b1;
                                    adpc_pkg::CMD_IRQ_TEST: begin
                                        fifo_clr = 1'b1;
                                        push_n   = 2'd1;
                                        push0    = 8'd0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                adpc_pkg::ACT_READ: begin
                    unique case (in_port_reg)
                        adpc_pkg::PORT_MIX_DATA: rd = mix_rdata;
                        adpc_pkg::PORT_READ_DATA: begin
                            if (count_reg != '0) begin
                                pop = 1'b1;
                                rd  = reply_store_reg[head_reg];
                            end
                        end
                        adpc_pkg::PORT_STATUS:
                            rd = (count_reg != '0) ? adpc_pkg::STATUS_READY : 8'd0;
                        default: ;
                    endcase
                end
                adpc_pkg::ACT_TICK: begin
                    if (dma_reg) begin
                        dac_next = in_ds_reg;
                        pos_next = pos_inc;
                        if (pos_inc > {1'b0, len_reg}) begin
                            irq = 1'b1;
                            if (auto_reg) begin
                                pos_next = 17'd0;
                            end else begin
                                dma_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // reply fifo: optional clear, then up to two pushes, or one pop
        base_head  = fifo_clr ? '0 : head_reg;
        base_count = fifo_clr ? '0 : count_reg;
        tail0      = wrap_add(base_head, base_count);
        we0        = (push_n != 2'd0) && (base_count < DEPTH_C);
        count1     = base_count + CW'(we0);
        tail1      = wrap_add(base_head, count1);
        we1        = (push_n == 2'd2) && (count1 < DEPTH_C);
        count_next = count1 + CW'(we1);
        head_next  = base_head;
        if (pop) begin
            head_next  = (head_reg == AW'(adpc_pkg::REPLY_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (we0) begin
            reply_store_reg[tail0] <= push0;
        end
        if (we1) begin
            reply_store_reg[tail1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            cmd_reg   <= 8'd0;
            phase_reg <= adpc_pkg::ARG_NONE;
            head_reg  <= '0;
            count_reg <= '0;
            spk_reg   <= 1'b0;
            dac_reg   <= 8'd0;
            dma_reg   <= 1'b0;
            auto_reg  <= 1'b0;
            len_reg   <= 16'd0;
            pos_reg   <= 17'd0;
            test_reg  <= 8'd0;
            ptr_reg   <= 8'd0;
        end else begin
            armed_reg <= armed_next;
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            spk_reg   <= spk_next;
            dac_reg   <= dac_next;
            dma_reg   <= dma_next;
            auto_reg  <= auto_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            test_reg  <= test_next;
            ptr_reg   <= ptr_next;
        end
    end

    // the next item's mixer read is issued at the pointer this item leaves
    always_comb begin
        mix_req.rd_en = s_accept;
        mix_req.raddr = ptr_next;
        mix_req.we    = mix_we;
        mix_req.waddr = ptr_reg;
        mix_req.wdata = in_wd_reg;
        mix_req.clear = mix_clr;
    end

    adpc_mixer u_mixer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mix_req),
        .rdata   (mix_rdata)
    );

endmodule
